>>> rtl/pmsfd_pkg.sv
// Constants shared by the particle sensor response frame decoder.
package pmsfd_pkg;

	localparam int unsigned POS_W          = 6;
	localparam int unsigned SUM_W          = 8;
	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned VALUE_W        = 32;
	localparam int unsigned INDEX_W        = 4;
	localparam int unsigned DATA_BYTES     = 52;
	localparam int unsigned FIRST_DATA_POS = 3;
	localparam int unsigned CHECKSUM_POS   = FIRST_DATA_POS + DATA_BYTES;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [INDEX_W-1:0] index_t;

endpackage

>>> rtl/pm_sensor_frame_decoder.sv
// Particle sensor response frame decoder: byte parser, checksum and reading store.
//
//   channel   valid       stall       payload
//   input     in_valid    in_stall    rx_byte, frame_start
//   output    out_valid   out_stall   reading_index, reading_value, frame_ok, last_result
//
// A header, length, command or summed-only byte is taken in S_IDLE; a data byte also passes
// through S_WRITE, as its reading is read from the store and written back shifted by one byte.
// A passing checksum emits READING_COUNT results via S_EMIT_RD, S_EMIT_LOAD and S_EMIT_OUT,
// held by out_stall; a failing checksum emits one result. The input is stalled throughout.
// Reset clears position, sum and control; the reading store holds no reset value.
module pm_sensor_frame_decoder #(
	parameter int unsigned READING_COUNT = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pmsfd_pkg::byte_t rx_byte,
	input  logic             frame_start,
	input  logic             in_valid,
	output logic             in_stall,
	output pmsfd_pkg::index_t reading_index,
	output pmsfd_pkg::value_t reading_value,
	output logic             frame_ok,
	output logic             last_result,
	output logic             out_valid,
	input  logic             out_stall
);
	import pmsfd_pkg::*;

	localparam int unsigned IDX_W = (READING_COUNT > 1) ? $clog2(READING_COUNT) : 1;
	localparam pos_t CHK_POS   = POS_W'(CHECKSUM_POS);
	localparam pos_t FIRST_POS = POS_W'(FIRST_DATA_POS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(READING_COUNT - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_EMIT_RD,
		S_EMIT_LOAD,
		S_EMIT_OUT
	} state_t;

	state_t           state_q;
	pos_t             pos_q;
	sum_t             sum_q;
	logic [IDX_W-1:0] wr_k_q;
	logic [IDX_W-1:0] emit_k_q;
	byte_t            byte_q;
	value_t           rd_q;
	value_t           mem [READING_COUNT];

	logic             in_acc;
	pos_t             data_off;
	logic [3:0]       data_k;
	logic             data_hit;
	logic [IDX_W-1:0] rd_addr;
	sum_t             sum_next;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign data_off = pos_q - FIRST_POS;
	assign data_k   = data_off[5:2];
	assign data_hit = (pos_q >= FIRST_POS) && (pos_q < CHK_POS)
		&& (32'(data_k) < READING_COUNT);
	assign sum_next = sum_q + rx_byte;

	always_comb begin
		rd_addr = '0;
		if (state_q == S_IDLE) begin
			if (data_hit) begin
				rd_addr = data_k[IDX_W-1:0];
			end
		end else begin
			rd_addr = emit_k_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (state_q == S_WRITE) begin
			mem[wr_k_q] <= {rd_q[VALUE_W-BYTE_W-1:0], byte_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pos_q         <= '0;
			sum_q         <= '0;
			wr_k_q        <= '0;
			emit_k_q      <= '0;
			byte_q        <= '0;
			out_valid     <= 1'b0;
			reading_index <= '0;
			reading_value <= '0;
			frame_ok      <= 1'b0;
			last_result   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (frame_start || pos_q == '0) begin
							pos_q <= POS_W'(1);
							sum_q <= rx_byte;
						end else if (pos_q < CHK_POS) begin
							pos_q <= pos_q + POS_W'(1);
							sum_q <= sum_next;
							if (data_hit) begin
								wr_k_q  <= data_k[IDX_W-1:0];
								byte_q  <= rx_byte;
								state_q <= S_WRITE;
							end
						end else begin
							pos_q    <= '0;
							sum_q    <= '0;
							emit_k_q <= '0;
							if (sum_next == '0) begin
								state_q <= S_EMIT_RD;
							end else begin
								out_valid     <= 1'b1;
								reading_index <= '0;
								reading_value <= '0;
								frame_ok      <= 1'b0;
								last_result   <= 1'b1;
								state_q       <= S_EMIT_OUT;
							end
						end
					end
				end
				S_WRITE: begin
					state_q <= S_IDLE;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LOAD;
				end
				S_EMIT_LOAD: begin
					out_valid     <= 1'b1;
					reading_index <= INDEX_W'(emit_k_q);
					reading_value <= rd_q;
					frame_ok      <= 1'b1;
					last_result   <= (emit_k_q == LAST_IDX);
					state_q       <= S_EMIT_OUT;
				end
				S_EMIT_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (last_result) begin
							state_q <= S_IDLE;
						end else begin
							emit_k_q <= emit_k_q + IDX_W'(1);
							state_q  <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
